// File: rtl/core/smpd_pkg.sv
// Shared types and constants for the serial mouse packet decoder.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package smpd_pkg;

    // Field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned ThrW    = 7;
    localparam int unsigned GainW   = 4;
    localparam int unsigned DeltaW  = 11;
    localparam int unsigned CfgDataW = 7;
    localparam int unsigned OutDataW = 24;

    // Register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_ACCEL_THRESHOLD = 1'b0,
        CFG_ACCEL_GAIN      = 1'b1
    } t_cfg_index;

    // Reset values of the configuration registers
    localparam logic [ThrW-1:0]  ThrReset  = 7'd5;
    localparam logic [GainW-1:0] GainReset = 4'd4;
    localparam logic [GainW-1:0] GainMax   = 4'd8;

    // Bit positions within a received byte
    localparam int unsigned StartBit = 6;
    localparam int unsigned LeftBit  = 5;
    localparam int unsigned RightBit = 4;

    // Raw fields of one completed packet
    typedef struct packed {
        logic [ByteW-1:0] dx_raw;
        logic [ByteW-1:0] dy_raw;
        logic             left_button;
        logic             right_button;
    } t_packet;

endpackage

// File: rtl/core/smpd_assembler.sv
// Byte assembler: tracks the byte count and holds bytes 0 and 1 of a packet.
// Depends on smpd_pkg.
`timescale 1ns / 1ps

module smpd_assembler
    import smpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [ByteW-1:0] i_rx_byte,
    output logic             o_done,
    output t_packet          o_packet
);

    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic [1:0]       count_eff;
    logic [ByteW-1:0] r_held0;
    logic [ByteW-1:0] r_held1;

    // A byte carrying the start mark restarts the packet at byte 0.
    assign count_eff = i_rx_byte[StartBit] ? 2'd0 : r_count;
    assign o_done    = (count_eff == 2'd2);

    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            n_count = o_done ? 2'd0 : count_eff + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Held bytes carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept && !o_done) begin
            if (count_eff[0]) begin
                r_held1 <= i_rx_byte;
            end else begin
                r_held0 <= i_rx_byte;
            end
        end
    end

    // Movement takes two high bits from byte 0 and six low bits from byte 1 or 2.
    assign o_packet.dx_raw       = {r_held0[1:0], r_held1[5:0]};
    assign o_packet.dy_raw       = {r_held0[3:2], i_rx_byte[5:0]};
    assign o_packet.left_button  = r_held0[LeftBit];
    assign o_packet.right_button = r_held0[RightBit];

endmodule

// File: rtl/core/smpd_accel.sv
// Acceleration for one axis: scales a movement whose magnitude exceeds the threshold.
// Depends on smpd_pkg.
`timescale 1ns / 1ps

module smpd_accel
    import smpd_pkg::*;
(
    input  logic [ByteW-1:0]  i_raw,
    input  logic [ThrW-1:0]   i_threshold,
    input  logic [GainW-1:0]  i_gain,
    output logic [DeltaW-1:0] o_delta
);

    logic signed [ByteW-1:0]  value;
    logic        [ByteW-1:0]  mag;
    logic        [GainW-1:0]  gain_lim;
    logic signed [11:0]       product;

    assign value = $signed(i_raw);
    // Magnitude of -128 is 128, which fits the unsigned byte.
    assign mag   = value[ByteW-1] ? (~i_raw + 8'd1) : i_raw;

    // Gains above eight are treated as eight.
    assign gain_lim = (i_gain > GainMax) ? GainMax : i_gain;
    assign product  = 12'(value) * $signed({8'd0, gain_lim});

    always_comb begin
        if (mag > {1'b0, i_threshold}) begin
            o_delta = product[DeltaW-1:0];
        end else begin
            o_delta = DeltaW'(value);
        end
    end

endmodule

// File: rtl/core/serial_mouse_packet_decoder_unit.sv
// Serial mouse packet decoder: top level with configuration and output register.
// Depends on smpd_pkg, smpd_assembler and smpd_accel.
//
// Usage:
//   The input channel (s_axis_*) carries one received serial byte per item.
//   A byte with bit 6 set starts a new packet. After the third byte of a
//   packet, one movement report appears on the output channel (m_axis_*).
//   Bytes 0 and 1 produce no output item.
//   The report is registered, valid in the cycle after the third byte is accepted.
//   Throughput: one byte per cycle unless a held report is not taken;
//   the decode and acceleration are short logic up to the single output register.
//   When the receiver stalls, the report holds in the output register and
//   s_axis_tready stays low until the report is taken; a new byte is accepted
//   in the same cycle in which the register is being emptied.
//   Reset (synchronous, active low) clears the byte count and the output
//   valid, and loads threshold 5 and gain 4.
//   i_cfg_we writes i_cfg_data to register i_cfg_index (0: acceleration threshold,
//   1: acceleration gain); the block relies on the user to write only while idle.
`timescale 1ns / 1ps

module serial_mouse_packet_decoder_unit
    import smpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    // Input channel
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
    // Output channel
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata    // [10:0] delta_x, [21:11] delta_y,
                                                // [22] left_button, [23] right_button
);

    logic [ThrW-1:0]     r_threshold;
    logic [GainW-1:0]    r_gain;
    logic                r_out_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                accept;
    logic                done;
    t_packet             packet;
    logic [DeltaW-1:0]   delta_x;
    logic [DeltaW-1:0]   delta_y;
    logic                out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ThrReset;
            r_gain      <= GainReset;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ACCEL_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_ACCEL_GAIN:      r_gain      <= i_cfg_data[GainW-1:0];
                default:             r_threshold <= r_threshold;
            endcase
        end
    end

    // Accept a byte whenever the output register is empty or being taken.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    smpd_assembler u_assembler (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (s_axis_tdata),
        .o_done    (done),
        .o_packet  (packet)
    );

    smpd_accel u_accel_x (
        .i_raw       (packet.dx_raw),
        .i_threshold (r_threshold),
        .i_gain      (r_gain),
        .o_delta     (delta_x)
    );

    smpd_accel u_accel_y (
        .i_raw       (packet.dy_raw),
        .i_threshold (r_threshold),
        .i_gain      (r_gain),
        .o_delta     (delta_y)
    );

    // Output register: loaded when a packet completes, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && done) begin
            r_out_data <= {packet.right_button, packet.left_button, delta_y, delta_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
